### rtl/srct_pkg.sv
`timescale 1ns / 1ps
// srct_pkg: shared constants, outcode bits and the command/status structs
// of the segment/rectangle clip test. No dependencies.
package srct_pkg;

	localparam int COORD_WIDTH_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 16;

	// internal fixed-point word and the full product
	localparam int DW = 64;
	localparam int PW = 2 * DW;
	localparam int HW = DW / 2;

	localparam logic [3:0] CODE_LEFT   = 4'd1;
	localparam logic [3:0] CODE_RIGHT  = 4'd2;
	localparam logic [3:0] CODE_BOTTOM = 4'd4;
	localparam logic [3:0] CODE_TOP    = 4'd8;

	localparam logic [2:0] MAX_MOVES = 3'd4;

	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_RIGHT  = 2'd1;
	localparam logic [1:0] REG_BOTTOM = 2'd2;
	localparam logic [1:0] REG_TOP    = 2'd3;

	typedef struct packed {
		logic       load;
		logic       setup;
		logic       mul;
		logic [1:0] mul_idx;
		logic       div;
		logic       commit;
	} srct_cmd_t;

	typedef struct packed {
		logic [3:0] c0;
		logic [3:0] c1;
	} srct_stat_t;

endpackage

### rtl/srct_datapath.sv
`timescale 1ns / 1ps
// srct_datapath: endpoint registers, outcodes, split multiplier and
// bit-serial divider. Depends on srct_pkg.
module srct_datapath import srct_pkg::*; #(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic [COORD_WIDTH-1:0] start_x,
	input  logic [COORD_WIDTH-1:0] start_y,
	input  logic [COORD_WIDTH-1:0] end_x,
	input  logic [COORD_WIDTH-1:0] end_y,
	input  logic [COORD_WIDTH-1:0] clip_left,
	input  logic [COORD_WIDTH-1:0] clip_right,
	input  logic [COORD_WIDTH-1:0] clip_bottom,
	input  logic [COORD_WIDTH-1:0] clip_top,
	input  srct_cmd_t              cmd,
	output srct_stat_t             stat
);

	function automatic logic signed [DW-1:0] to_fixed(input logic [COORD_WIDTH-1:0] v);
		logic signed [DW-1:0] e;
		e = DW'($signed(v));
		return e <<< FRACTION_BITS;
	endfunction

	function automatic logic [3:0] outcode(input logic signed [DW-1:0] x,
		input logic signed [DW-1:0] y, input logic signed [DW-1:0] xl,
		input logic signed [DW-1:0] xr, input logic signed [DW-1:0] yb,
		input logic signed [DW-1:0] yt);
		logic [3:0] c;
		c = 4'd0;
		if (x < xl) c = c | CODE_LEFT;
		else if (x > xr) c = c | CODE_RIGHT;
		if (y < yb) c = c | CODE_BOTTOM;
		else if (y > yt) c = c | CODE_TOP;
		return c;
	endfunction

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	logic signed [DW-1:0] xl, xr, yb, yt;
	logic signed [DW-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [DW-1:0] ma_q, mb_q, md_q, quo_q, rem_q;
	logic signed [DW-1:0] base_q, edge_q;
	logic neg_q, zero_q, vert_q, mv0_q;
	logic [PW-1:0] acc_q;

	assign xl = to_fixed(clip_left);
	assign xr = to_fixed(clip_right);
	assign yb = to_fixed(clip_bottom);
	assign yt = to_fixed(clip_top);

	assign stat.c0 = outcode(x0_q, y0_q, xl, xr, yb, yt);
	assign stat.c1 = outcode(x1_q, y1_q, xl, xr, yb, yt);

	// edge selection for the setup step
	logic [3:0] co;
	logic signed [DW-1:0] sa, sb, sd, sbase, sedge;
	logic svert;
	always_comb begin
		co = (stat.c0 != 4'd0) ? stat.c0 : stat.c1;
		if ((co & CODE_TOP) != 4'd0) begin
			sa = x1_q - x0_q; sb = yt - y0_q; sd = y1_q - y0_q;
			sbase = x0_q; sedge = yt; svert = 1'b1;
		end else if ((co & CODE_BOTTOM) != 4'd0) begin
			sa = x1_q - x0_q; sb = yb - y0_q; sd = y1_q - y0_q;
			sbase = x0_q; sedge = yb; svert = 1'b1;
		end else if ((co & CODE_RIGHT) != 4'd0) begin
			sa = y1_q - y0_q; sb = xr - x0_q; sd = x1_q - x0_q;
			sbase = y0_q; sedge = xr; svert = 1'b0;
		end else begin
			sa = y1_q - y0_q; sb = xl - x0_q; sd = x1_q - x0_q;
			sbase = y0_q; sedge = xl; svert = 1'b0;
		end
	end

	// one 32x32 partial product per step
	logic [HW-1:0] pa, pb;
	logic [DW-1:0] part;
	logic [PW-1:0] part_sh;
	always_comb begin
		pa = cmd.mul_idx[0] ? ma_q[DW-1:HW] : ma_q[HW-1:0];
		pb = cmd.mul_idx[1] ? mb_q[DW-1:HW] : mb_q[HW-1:0];
		part = DW'(pa) * DW'(pb);
		case (cmd.mul_idx)
			2'd0:    part_sh = PW'(part);
			2'd3:    part_sh = PW'(part) << DW;
			default: part_sh = PW'(part) << HW;
		endcase
	end

	// restoring divide step, dividend shifted out of acc msb first
	logic [DW:0] rem_n;
	logic rge;
	assign rem_n = {rem_q, acc_q[PW-1]};
	assign rge = rem_n >= {1'b0, md_q};

	logic signed [DW-1:0] q_s, nv;
	assign q_s = zero_q ? '0 : (neg_q ? DW'(-$signed(quo_q)) : $signed(quo_q));
	assign nv = base_q + q_s;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= to_fixed(start_x);
			y0_q <= to_fixed(start_y);
			x1_q <= to_fixed(end_x);
			y1_q <= to_fixed(end_y);
		end
		if (cmd.setup) begin
			ma_q   <= mag(sa);
			mb_q   <= mag(sb);
			md_q   <= mag(sd);
			neg_q  <= sa[DW-1] ^ sb[DW-1] ^ sd[DW-1];
			zero_q <= (sa == '0) || (sb == '0) || (sd == '0);
			base_q <= sbase;
			edge_q <= sedge;
			vert_q <= svert;
			mv0_q  <= stat.c0 != 4'd0;
			acc_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end
		if (cmd.mul) acc_q <= acc_q + part_sh;
		if (cmd.div) begin
			acc_q <= {acc_q[PW-2:0], 1'b0};
			rem_q <= rge ? DW'(rem_n - {1'b0, md_q}) : rem_n[DW-1:0];
			quo_q <= {quo_q[DW-2:0], rge};
		end
		if (cmd.commit) begin
			if (mv0_q) begin
				x0_q <= vert_q ? nv : edge_q;
				y0_q <= vert_q ? edge_q : nv;
			end else begin
				x1_q <= vert_q ? nv : edge_q;
				y1_q <= vert_q ? edge_q : nv;
			end
		end
	end

endmodule

### rtl/srct_ctrl.sv
`timescale 1ns / 1ps
// srct_ctrl: sequencer for the clip loop and the result register.
// Depends on srct_pkg.
module srct_ctrl import srct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       accept,
	input  srct_stat_t stat,
	output srct_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	logic [2:0] state_q;
	logic [6:0] cnt_q;
	logic [2:0] moves_q;
	logic       result_q;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;
	assign accept    = result_q;

	always_comb begin
		cmd = '0;
		cmd.load    = in_valid && in_ready;
		cmd.setup   = (state_q == ST_DECIDE) && ((stat.c0 | stat.c1) != 4'd0)
			&& ((stat.c0 & stat.c1) == 4'd0) && (moves_q < MAX_MOVES);
		cmd.mul     = state_q == ST_MUL;
		cmd.mul_idx = cnt_q[1:0];
		cmd.div     = state_q == ST_DIV;
		cmd.commit  = state_q == ST_COMMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			moves_q  <= '0;
			result_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						moves_q <= '0;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if ((stat.c0 | stat.c1) == 4'd0) begin
						result_q <= 1'b1;
						state_q  <= ST_OUT;
					end else if (!cmd.setup) begin
						result_q <= 1'b0;
						state_q  <= ST_OUT;
					end else begin
						moves_q <= moves_q + 3'd1;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q <= (cnt_q == 7'd3) ? 7'd0 : cnt_q + 7'd1;
					if (cnt_q == 7'd3) state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) state_q <= ST_COMMIT;
				end
				ST_COMMIT: state_q <= ST_DECIDE;
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_moves_bound: assert property (@(posedge clk) disable iff (!arst_n)
		moves_q <= MAX_MOVES) else $error("move count past limit");
	a_load_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_DECIDE) else $error("request not sequenced");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.setup, cmd.mul, cmd.div, cmd.commit}))
		else $error("overlapping datapath commands");
	a_div_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == 7'd127) |=> state_q == ST_COMMIT)
		else $error("divide did not finish into commit");

endmodule

### rtl/segment_rectangle_clip_test_unit.sv
`timescale 1ns / 1ps
// segment_rectangle_clip_test_unit: top level, clip rectangle registers,
// controller and datapath. Depends on srct_pkg, srct_ctrl, srct_datapath.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_ready   | start_x, start_y, end_x, end_y
//  out     | out_valid / out_ready | accept
//  cfg     | cfg_we                | cfg_index, cfg_data
//
// A request takes 0..4 clipping moves (1 setup, 4 partial-product steps,
// 128 divide steps, 1 commit each); the bit-serial 128/64 divider is the
// longest part of each move.
// One request at a time: in_ready is high only while idle.
// The result holds on out_valid until out_ready; no new request meanwhile.
// arst_n clears the controller and the rectangle (all edges 0).
module segment_rectangle_clip_test_unit import srct_pkg::*; #(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COORD_WIDTH-1:0] start_x,
	input  logic [COORD_WIDTH-1:0] start_y,
	input  logic [COORD_WIDTH-1:0] end_x,
	input  logic [COORD_WIDTH-1:0] end_y,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   accept,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);

	// clip rectangle, integer coordinates
	logic [COORD_WIDTH-1:0] left_q, right_q, bottom_q, top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= '0;
			bottom_q <= '0;
			top_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT:   left_q   <= cfg_data;
				REG_RIGHT:  right_q  <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_TOP:    top_q    <= cfg_data;
				default:    ;
			endcase
		end
	end

	srct_cmd_t  cmd;
	srct_stat_t stat;

	srct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.accept    (accept),
		.stat      (stat),
		.cmd       (cmd)
	);

	srct_datapath #(
		.COORD_WIDTH   (COORD_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk         (clk),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.clip_left   (left_q),
		.clip_right  (right_q),
		.clip_bottom (bottom_q),
		.clip_top    (top_q),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule
